/* rtl/core/lmsel_pkg.sv */
// Shared types and constants for the lower median selector.
package lmsel_pkg;

  // Width of one stored value
  localparam int VALUE_W = 32;

  // Default store capacity
  localparam int MAX_ITEMS_DEF = 512;

  // One incoming item
  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      set_end;
  } lms_in_t;

  // One result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] median_value;
    logic                      dropped_flag;
  } lms_out_t;

  // Control from the sequencer to the rank counter
  typedef struct packed {
    logic clr;  // start a new candidate
    logic en;   // read data is valid, count it
  } lms_rank_ctl_t;

endpackage

/* rtl/core/lmsel_store.sv */
// Value store: one write port, one read port with registered read data.
module lmsel_store
  import lmsel_pkg::*;
#(
  parameter int DEPTH = MAX_ITEMS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic signed [VALUE_W-1:0] rdata
);

  logic signed [VALUE_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lmsel_rank.sv */
// Shared compare unit: counts stored values below and not above a candidate.
module lmsel_rank
  import lmsel_pkg::*;
#(
  parameter int CW = $clog2(MAX_ITEMS_DEF + 1)
) (
  input  logic                      clk,
  input  lms_rank_ctl_t             ctl,
  input  logic signed [VALUE_W-1:0] cand,
  input  logic signed [VALUE_W-1:0] data,
  input  logic [CW-1:0]             rank,
  output logic                      hit
);

  logic [CW-1:0] below;
  logic [CW-1:0] not_above;
  logic          is_below;
  logic          is_equal;

  // Signed compare of one stored value against the candidate
  assign is_below = (data < cand);
  assign is_equal = (data == cand);

  // Running counts over one scan
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      below     <= '0;
      not_above <= '0;
    end else if (ctl.en) begin
      if (is_below) begin
        below <= below + CW'(1);
      end
      if (is_below || is_equal) begin
        not_above <= not_above + CW'(1);
      end
    end
  end

  // Candidate sits at the wanted sorted position
  assign hit = (below <= rank) && (rank < not_above);

endmodule

/* rtl/core/lower_median_selector.sv */
// Lower median selector: loads a set of signed values, then returns its lower median.
// Loading: one item per cycle, busy stays low; a set_end item starts selection.
// Selection walks the store once per candidate through one compare unit and one
// memory read port, trying candidates in store order until one has the wanted rank.
// The result strobe (done) is high for one cycle and cannot be stalled.
// Synchronous reset clears count, overflow flag and sequencer; the store is not cleared.
module lower_median_selector
  import lmsel_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  lms_in_t  sample,
  output logic     done,
  output lms_out_t result
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_CAND,
    S_CLATCH,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  state_t                    state;
  logic [CW-1:0]             count;
  logic                      ovf;
  logic [AW-1:0]             cand_idx;
  logic [AW-1:0]             scan_idx;
  logic signed [VALUE_W-1:0] cand;
  logic                      cmp_vld;

  logic                      accept;
  logic                      full;
  logic                      wr_en;
  logic [AW-1:0]             rd_addr;
  logic signed [VALUE_W-1:0] rd_data;
  logic [CW-1:0]             rank;
  logic                      last_scan;
  logic                      hit;
  lms_rank_ctl_t             rank_ctl;

  assign busy      = (state != S_LOAD);
  assign accept    = start && !busy;
  assign full      = (count == CW'(MAX_ITEMS));
  assign wr_en     = accept && !full;
  assign rank      = (count - CW'(1)) >> 1;
  assign last_scan = (CW'(scan_idx) == count - CW'(1));
  assign rd_addr   = (state == S_CAND) ? cand_idx : scan_idx;

  assign rank_ctl.clr = (state == S_CLATCH);
  assign rank_ctl.en  = cmp_vld;

  lmsel_store #(
    .DEPTH (MAX_ITEMS),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (sample.sample_value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lmsel_rank #(
    .CW (CW)
  ) u_rank (
    .clk  (clk),
    .ctl  (rank_ctl),
    .cand (cand),
    .data (rd_data),
    .rank (rank),
    .hit  (hit)
  );

  // Sequencer: load, then for each candidate scan the store and test its rank
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      ovf      <= 1'b0;
      cand_idx <= '0;
      scan_idx <= '0;
      cmp_vld  <= 1'b0;
      done     <= 1'b0;
    end else begin
      done    <= 1'b0;
      cmp_vld <= (state == S_SCAN);
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (full) begin
              ovf <= 1'b1;
            end else begin
              count <= count + CW'(1);
            end
            if (sample.set_end) begin
              cand_idx <= '0;
              state    <= S_CAND;
            end
          end
        end
        S_CAND: begin
          state <= S_CLATCH;
        end
        S_CLATCH: begin
          cand     <= rd_data;
          scan_idx <= '0;
          state    <= S_SCAN;
        end
        S_SCAN: begin
          if (last_scan) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + AW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (hit) begin
            done                <= 1'b1;
            result.median_value <= cand;
            result.dropped_flag <= ovf;
            count               <= '0;
            ovf                 <= 1'b0;
            state               <= S_LOAD;
          end else begin
            cand_idx <= cand_idx + AW'(1);
            state    <= S_CAND;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

/* rtl/core/lmsel_chk.sv */
// Port-level checker for the lower median selector, bound to the top level.
module lmsel_chk
  import lmsel_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input lms_in_t  sample,
  input logic     done,
  input lms_out_t result
);

  // A result only follows a selection in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without preceding selection");

  // A closing item starts selection
  a_end_starts_sel: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && sample.set_end) |=> busy)
    else $error("closing item did not start selection");

  // A plain item keeps the block loading and gives no result
  a_plain_item: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !sample.set_end) |=> (!busy && !done))
    else $error("non-closing item changed state or gave a result");

  // After a result the block is ready again unless a new set closes at once
  a_ready_after_done: assert property (@(posedge clk) disable iff (rst)
    (done && !(start && sample.set_end)) |=> !busy)
    else $error("block not ready after result");

endmodule

bind lower_median_selector lmsel_chk u_lmsel_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .sample (sample),
  .done   (done),
  .result (result)
);

/* sim/tb_top.sv */
// Testbench for the lower median selector: random sets of signed values checked by a sorting model.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import lmsel_pkg::*;

  localparam int CAPACITY     = MAX_ITEMS_DEF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int DRAIN_CYCLES = 200;

  // How the values of one random set are drawn
  typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EDGE, VAL_MIXED} val_style_t;

  logic     clk    = 1'b0;
  logic     rst    = 1'b1;
  logic     start  = 1'b0;
  lms_in_t  sample = '0;
  logic     busy;
  logic     done;
  lms_out_t result;

  lower_median_selector #(.MAX_ITEMS(CAPACITY)) u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .sample (sample),
    .done   (done),
    .result (result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  lms_in_t                   pending_samples[$];
  lms_out_t                  due_medians[$];
  logic signed [VALUE_W-1:0] loaded_vals[$];
  bit                        loaded_dropped = 1'b0;
  int                        reset_left = 9;
  int                        idle_left = 0;
  int                        burst_left = 1;
  int                        fail_count = 0;
  int                        cycle_count = 0;

  // Lower median of the values kept so far: sorted position (n-1)/2
  function automatic logic signed [VALUE_W-1:0] lower_median_of_loaded();
    logic signed [VALUE_W-1:0] sorted_vals[$];
    logic signed [VALUE_W-1:0] key;
    int                        j;
    sorted_vals = {};
    foreach (loaded_vals[i]) begin
      key = loaded_vals[i];
      j = sorted_vals.size();
      while (j > 0 && sorted_vals[j-1] > key) j--;
      sorted_vals.insert(j, key);
    end
    return sorted_vals[(sorted_vals.size() - 1) / 2];
  endfunction

  // Take one accepted item into the set; a closing item yields the expected median
  task automatic absorb_sample(input lms_in_t s);
    lms_out_t r;
    if (loaded_vals.size() < CAPACITY) begin
      loaded_vals.push_back(s.sample_value);
    end else begin
      loaded_dropped = 1'b1;
    end
    if (s.set_end) begin
      r.median_value = lower_median_of_loaded();
      r.dropped_flag = loaded_dropped;
      due_medians.push_back(r);
      loaded_vals = {};
      loaded_dropped = 1'b0;
    end
  endtask

  task automatic add_sample(input logic signed [VALUE_W-1:0] v, input bit last);
    lms_in_t s;
    s.sample_value = v;
    s.set_end = last;
    pending_samples.push_back(s);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value(input val_style_t style);
    val_style_t pick;
    pick = style;
    if (pick == VAL_MIXED) pick = val_style_t'($urandom_range(0, 2));
    case (pick)
      VAL_NARROW: return int'($urandom_range(0, 8)) - 4;   // many duplicates
      VAL_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return -1;
          default: return 0;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // One set of n values, the last one closing it
  task automatic add_set(input int n, input val_style_t style);
    for (int k = 0; k < n; k++) add_sample(pick_value(style), k == n - 1);
  endtask

  // Driver: reset, then items from the pending queue in bursts with idle gaps
  always @(negedge clk) begin
    if (reset_left != 0) begin
      reset_left--;
      if (reset_left == 0) rst <= 1'b0;
      start <= 1'b0;
    end else if (idle_left != 0) begin
      idle_left--;
      start <= 1'b0;
    end else if (pending_samples.size() != 0) begin
      start  <= 1'b1;
      sample <= pending_samples[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check a result first, then record an accepted item
  always @(posedge clk) begin
    lms_out_t want;
    if (!rst && done) begin
      if (due_medians.size() == 0) begin
        $error("unexpected result: median_value %0d dropped_flag %0b",
               result.median_value, result.dropped_flag);
        fail_count++;
      end else begin
        want = due_medians.pop_front();
        if (result.median_value !== want.median_value) begin
          $error("median_value: expected %0d, actual %0d",
                 want.median_value, result.median_value);
          fail_count++;
        end
        if (result.dropped_flag !== want.dropped_flag) begin
          $error("dropped_flag: expected %0b, actual %0b",
                 want.dropped_flag, result.dropped_flag);
          fail_count++;
        end
      end
    end
    if (!rst && start && !busy) begin
      absorb_sample(sample);
      void'(pending_samples.pop_front());
      burst_left--;
      if (burst_left <= 0) begin
        // about a third of the bursts run straight into the next one
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 2) == 0) idle_left = 0;
        else if ($urandom_range(0, 3) == 0) idle_left = $urandom_range(1, 25);
        else idle_left = $urandom_range(1, 4);
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int         set_no;
    int         n;
    int         random_queued;
    val_style_t style;

    // single-value sets at both ends of the range
    add_sample(32'sh7FFF_FFFF, 1'b1);
    add_sample(32'sh8000_0000, 1'b1);
    // even and odd counts; an even count picks the lower of the middle pair
    add_sample(-1, 1'b0);
    add_sample(1, 1'b1);
    add_sample(32'sh7FFF_FFFF, 1'b0);
    add_sample(32'sh8000_0000, 1'b0);
    add_sample(0, 1'b1);
    // duplicates count separately
    add_sample(5, 1'b0);
    add_sample(5, 1'b0);
    add_sample(5, 1'b0);
    add_sample(-5, 1'b1);
    // compares whose difference would overflow
    add_sample(32'sh8000_0000, 1'b0);
    add_sample(32'sh7FFF_FFFF, 1'b0);
    add_sample(32'sh8000_0000, 1'b0);
    add_sample(32'sh7FFF_FFFF, 1'b1);
    add_sample(-2_000_000_000, 1'b0);
    add_sample(2_000_000_000, 1'b0);
    add_sample(1, 1'b1);
    add_sample(32'sh5555_5555, 1'b0);
    add_sample(32'shAAAA_AAAA, 1'b1);

    // random sets, mostly short; one exactly full and one past capacity
    set_no = 0;
    random_queued = 0;
    while (random_queued < RANDOM_ITEMS) begin
      set_no++;
      if (set_no == 15) n = CAPACITY;
      else if (set_no == 60) n = CAPACITY + $urandom_range(1, 4);
      else if ($urandom_range(0, 9) == 0) n = $urandom_range(9, 40);
      else n = $urandom_range(1, 8);
      style = val_style_t'($urandom_range(0, 3));
      add_set(n, style);
      random_queued += n;
    end

    wait (pending_samples.size() == 0);
    wait (due_medians.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
